// ===== sv/dsdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dsdt_pkg
// Shared types and constants for the display shadow dirty tracker: item
// kinds, field widths, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsdt_pkg;

   // Field widths of the request and response beats.
   localparam int KIND_W = 2;
   localparam int CH_W   = 8;
   localparam int MASK_W = 32;

   // Default number of display positions held in the shadow.
   localparam int POSITIONS_DEF = 32;

   // Character written into positions that are cleared.
   localparam logic [CH_W-1:0] BLANK_CHAR = 8'h20;

   // Item kinds carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic char_start;   // latch the character and read its shadow entry
      logic char_write;   // compare and write the character
      logic ack;          // clear acknowledged mask bits
      logic end_start;    // start the blanking scan at the write position
      logic blk_read;     // read the shadow entry under the scan pointer
      logic blk_write;    // blank the scanned entry when needed
      logic finish;       // close the string and load the response register
   } dsdt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wpos_full;    // the string already filled every position
      logic scan_active;  // the scan pointer is still inside the blank range
   } dsdt_status_type;

endpackage

// ===== sv/dsdt_datapath.sv =====
// ----------------------------------------------------------------------------
// dsdt_datapath
// Shadow memory, string counters, dirty mask and response register. Works
// one step at a time under the commands of the controller.
// ----------------------------------------------------------------------------
module dsdt_datapath #(
   parameter int POSITIONS = dsdt_pkg::POSITIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsdt_pkg::dsdt_cmd_type        cmd,
   output dsdt_pkg::dsdt_status_type     status,
   input  logic [dsdt_pkg::CH_W-1:0]     req_ch,
   input  logic [dsdt_pkg::MASK_W-1:0]   req_ack_mask,
   output logic [dsdt_pkg::MASK_W-1:0]   rsp_dirty_mask,
   output logic                          rsp_update_request
);
   import dsdt_pkg::*;

   localparam int IDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int CNT_W = $clog2(POSITIONS + 1);
   localparam logic [CNT_W-1:0] POS_COUNT = CNT_W'(POSITIONS);

   // Mask bit of one position; positions past the mask width have none.
   function automatic logic [MASK_W-1:0] pos_bit(input logic [CNT_W-1:0] p);
      logic [MASK_W-1:0] b;
      logic [7:0]        pe;
      pe = 8'(p);
      for (int i = 0; i < MASK_W; i++) begin
         b[i] = (pe == 8'(i));
      end
      return b;
   endfunction

   // Mask with a bit for every position that exists.
   function automatic logic [MASK_W-1:0] all_bits();
      logic [MASK_W-1:0] b;
      for (int i = 0; i < MASK_W; i++) begin
         b[i] = (i < POSITIONS);
      end
      return b;
   endfunction

   logic [CH_W-1:0]   shadow_mem [POSITIONS];
   logic [CH_W-1:0]   rd_data_ff;
   logic [CH_W-1:0]   char_ff;
   logic [CNT_W-1:0]  wpos_ff, wpos_in;
   logic [CNT_W-1:0]  prev_end_ff, prev_end_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [MASK_W-1:0] dirty_ff, dirty_in;
   logic              primed_ff, primed_in;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_upd_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [CH_W-1:0]   mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic [CNT_W-1:0]  scan_limit;
   logic [MASK_W-1:0] fin_mask;
   logic              char_differs;
   logic              blk_needed;

   // Scan bound: the first string pads every position, later ones only up
   // to the previous end.
   assign scan_limit = primed_ff ? prev_end_ff : POS_COUNT;

   assign status.wpos_full   = (wpos_ff >= POS_COUNT);
   assign status.scan_active = (scan_ff < scan_limit);

   assign char_differs = (rd_data_ff != char_ff);
   assign blk_needed   = !primed_ff || (rd_data_ff != BLANK_CHAR);
   assign fin_mask     = primed_ff ? dirty_ff : all_bits();

   // Shadow memory port selection.
   always_comb begin
      mem_re    = cmd.char_start || cmd.blk_read;
      mem_raddr = cmd.char_start ? wpos_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      mem_we    = cmd.char_write || (cmd.blk_write && blk_needed);
      mem_waddr = cmd.char_write ? wpos_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      mem_wdata = cmd.char_write ? char_ff : BLANK_CHAR;
   end

   // Next values of the counters and the dirty mask.
   always_comb begin
      wpos_in     = wpos_ff;
      prev_end_in = prev_end_ff;
      scan_in     = scan_ff;
      dirty_in    = dirty_ff;
      primed_in   = primed_ff;
      if (cmd.ack) begin
         dirty_in = dirty_ff & ~req_ack_mask;
      end
      if (cmd.char_write) begin
         wpos_in = wpos_ff + CNT_W'(1);
         if (primed_ff && char_differs) begin
            dirty_in = dirty_ff | pos_bit(wpos_ff);
         end
      end
      if (cmd.end_start) begin
         scan_in = wpos_ff;
      end
      if (cmd.blk_write) begin
         scan_in = scan_ff + CNT_W'(1);
         if (primed_ff && blk_needed) begin
            dirty_in = dirty_ff | pos_bit(scan_ff);
         end
      end
      if (cmd.finish) begin
         dirty_in    = fin_mask;
         primed_in   = 1'b1;
         prev_end_in = wpos_ff;
         wpos_in     = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         prev_end_ff <= '0;
         dirty_ff    <= '0;
         primed_ff   <= 1'b0;
      end else begin
         wpos_ff     <= wpos_in;
         prev_end_ff <= prev_end_in;
         dirty_ff    <= dirty_in;
         primed_ff   <= primed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (cmd.char_start) begin
         char_ff <= req_ch;
      end
      if (cmd.finish) begin
         rsp_mask_ff <= fin_mask;
         rsp_upd_ff  <= (fin_mask != '0);
      end
   end

   // Shadow memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= shadow_mem[mem_raddr];
      end
   end

   assign rsp_dirty_mask     = rsp_mask_ff;
   assign rsp_update_request = rsp_upd_ff;

endmodule

// ===== sv/dsdt_control.sv =====
// ----------------------------------------------------------------------------
// dsdt_control
// Sequencer for the dirty tracker. Takes request beats, steps the datapath
// through the character update or the blanking scan, and owns the response
// valid flag.
// ----------------------------------------------------------------------------
module dsdt_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsdt_pkg::KIND_W-1:0]   req_kind,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  dsdt_pkg::dsdt_status_type     status,
   output dsdt_pkg::dsdt_cmd_type        cmd
);
   import dsdt_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHAR_WR = 3'd1;
   localparam logic [2:0] ST_BLK_RD  = 3'd2;
   localparam logic [2:0] ST_BLK_WR  = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Requests are taken only while no item is in progress.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_CHAR: begin
                     if (!status.wpos_full) begin
                        cmd.char_start = 1'b1;
                        state_in       = ST_CHAR_WR;
                     end
                  end
                  KIND_END: begin
                     cmd.end_start = 1'b1;
                     state_in      = ST_BLK_RD;
                  end
                  KIND_ACK: begin
                     cmd.ack = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CHAR_WR: begin
            cmd.char_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_BLK_RD: begin
            if (status.scan_active) begin
               cmd.blk_read = 1'b1;
               state_in     = ST_BLK_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_BLK_WR: begin
            cmd.blk_write = 1'b1;
            state_in      = ST_BLK_RD;
         end
         ST_FINISH: begin
            // Wait until the response register is free.
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on finish, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/display_shadow_dirty_tracker.sv =====
// ----------------------------------------------------------------------------
// display_shadow_dirty_tracker
// Shadow copy of a text display with a mask of changed positions.
// ----------------------------------------------------------------------------
// Strings arrive one character per request beat and are closed by an end
// beat, which returns one response beat with the 32-bit dirty mask and an
// update request flag; character and acknowledge beats return nothing, and
// an acknowledge beat clears mask bits at once. Characters past POSITIONS
// are dropped. The shadow sits in a memory with one registered read port and
// one write port, and an entry is read, then written. A character beat reads
// and writes the entry at the write position (nothing once the string is
// full). An end beat starts the scan, then reads and writes each position
// scanned for blanking (from the string's length to the previous length, or
// to POSITIONS for the first string after reset), and then closes the string.
// A finished response waits in an output register, so character and
// acknowledge beats are still taken while it is stalled. The next end beat,
// however, holds in its last cycle with the request port stalled until that
// earlier response beat has been taken.
// ----------------------------------------------------------------------------
module display_shadow_dirty_tracker #(
   parameter int POSITIONS = dsdt_pkg::POSITIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsdt_pkg::KIND_W-1:0]   req_kind,
   input  logic [dsdt_pkg::CH_W-1:0]     req_ch,
   input  logic [dsdt_pkg::MASK_W-1:0]   req_ack_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsdt_pkg::MASK_W-1:0]   rsp_dirty_mask,
   output logic                          rsp_update_request
);
   import dsdt_pkg::*;

   dsdt_cmd_type    cmd;
   dsdt_status_type status;

   // Sequencer.
   dsdt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Shadow memory, counters and mask.
   dsdt_datapath #(
      .POSITIONS (POSITIONS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_ch             (req_ch),
      .req_ack_mask       (req_ack_mask),
      .rsp_dirty_mask     (rsp_dirty_mask),
      .rsp_update_request (rsp_update_request)
   );

`ifndef SYNTHESIS
   // The update request agrees with the reported mask whenever a response is valid.
   a_upd_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_update_request == (rsp_dirty_mask != '0)))
      else $error("update request disagrees with dirty mask");

   // A string is closed only when the response register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // Every closed string presents a response beat.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("closed string gave no response beat");

   // Blanking steps never run while requests are being taken.
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.blk_read || cmd.blk_write || cmd.char_write) |-> req_stall)
      else $error("datapath step while request port open");
`endif

endmodule
